[hw/rtl/matrix_hash_linear_probe_table_top_defines.svh]
// assertion macros for the hash table block
`ifndef MATRIX_HASH_LINEAR_PROBE_TABLE_TOP_DEFINES_SVH
`define MATRIX_HASH_LINEAR_PROBE_TABLE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HMLPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define HMLPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HMLPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`define HMLPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/hmlpt_pkg.sv]
// types and codes shared by the hash table block
package hmlpt_pkg;

    localparam int HMLPT_VALUE_W    = 16;
    localparam int HMLPT_VALUE_BITS = 16;
    localparam int HMLPT_ROWS       = 8;
    localparam int HMLPT_ROW_IDX_W  = $clog2(HMLPT_ROWS);

    localparam logic [HMLPT_VALUE_W-1:0] HMLPT_VALUE_MASK =
        HMLPT_VALUE_W'((64'd1 << HMLPT_VALUE_BITS) - 64'd1);

    typedef logic [1:0]                 t_cmd;
    typedef logic [1:0]                 t_status;
    typedef logic [HMLPT_VALUE_W-1:0]   t_value;
    typedef logic [HMLPT_ROW_IDX_W-1:0] t_row_idx;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_DELETE = 2'd1;
    localparam t_cmd CMD_SEARCH = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_MISS = 2'd1;
    localparam t_status ST_FULL = 2'd2;

endpackage

[hw/rtl/matrix_hash_linear_probe_table_top.sv]
// open-addressed hash set with gf(2) matrix hash and linear probing
//
// input channel: i_in_valid / o_in_ready carry one item (i_cmd, i_item_value);
// cmd insert, delete or search. output channel: o_out_valid / i_out_ready
// carry one o_status per item (done/found, not found/invalid, full).
// config: i_cfg_we writes i_cfg_wdata to hash row i_cfg_idx, no wait.
// one item at a time: after acceptance the block computes the home slot in
// its hash step, then walks the slot memory one probe per cycle through its
// single registered read port and one compare unit, until an empty slot,
// a match or a full lap, so 1 to 2^KEY_BITS probes; a zero value or unused
// command skips the walk and gets the not found/invalid status; the next
// item is taken the cycle after the result is posted.
// a finished result waits in an output register, so a stalled receiver
// only holds the sequencer in its last step, and the next item is accepted
// while that result still waits.
// reset clears the hash rows and marks every slot empty through per-slot
// valid bits; no clearing pass is needed.
module matrix_hash_linear_probe_table_top #(
    parameter int KEY_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  hmlpt_pkg::t_row_idx           i_cfg_idx,
    input  hmlpt_pkg::t_value             i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hmlpt_pkg::t_cmd               i_cmd,
    input  hmlpt_pkg::t_value             i_item_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hmlpt_pkg::t_status            o_status
);
    import hmlpt_pkg::*;

`include "matrix_hash_linear_probe_table_top_defines.svh"

    localparam int TABLE_SLOTS = 1 << KEY_BITS;
    localparam int ENTRY_W     = HMLPT_VALUE_W + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HASH  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]          r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    t_value              r_value, n_value;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [KEY_BITS-1:0] r_cnt, n_cnt;
    t_status             r_status, n_status;
    logic                r_out_vld, n_out_vld;
    t_status             r_out_status, n_out_status;

    t_value              r_hash_row [HMLPT_ROWS];
    logic [ENTRY_W-1:0]  r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_vld;
    logic [ENTRY_W-1:0]  r_rd_data;
    logic                r_rd_vld;

    logic [KEY_BITS-1:0] hash_key;
    logic [KEY_BITS-1:0] slot;
    logic [KEY_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [ENTRY_W-1:0]  wr_data;
    logic                hit_used;
    logic                data_eq;
    logic                last_probe;

    // key bit i is the parity of row i and the masked value
    always_comb begin
        for (int i = 0; i < KEY_BITS; i++) begin
            hash_key[i] = ^(r_hash_row[i] & r_value & HMLPT_VALUE_MASK);
        end
    end

    assign slot       = r_key + r_cnt;
    assign rd_addr    = (r_state == S_HASH) ? hash_key : slot + KEY_BITS'(1);
    assign hit_used   = r_rd_vld && r_rd_data[HMLPT_VALUE_W];
    assign data_eq    = (r_rd_data[HMLPT_VALUE_W-1:0] == r_value);
    assign last_probe = (r_cnt == {KEY_BITS{1'b1}});

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_value      = r_value;
        n_key        = r_key;
        n_cnt        = r_cnt;
        n_status     = r_status;
        n_out_vld    = r_out_vld && !i_out_ready;
        n_out_status = r_out_status;
        wr_en        = 1'b0;
        wr_data      = {1'b1, r_value};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_value = i_item_value;
                    if (i_item_value == '0 ||
                        (i_cmd != CMD_INSERT && i_cmd != CMD_DELETE &&
                         i_cmd != CMD_SEARCH)) begin
                        n_status = ST_MISS;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                n_key   = hash_key;
                n_cnt   = '0;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                n_cnt = r_cnt + KEY_BITS'(1);
                case (r_cmd)
                    CMD_INSERT: begin
                        // home slot reuses tombstones, later probes only empty slots
                        if ((r_cnt == '0) ? !hit_used : !r_rd_vld) begin
                            wr_en    = 1'b1;
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end else if (last_probe) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end
                    end
                    default: begin
                        if (!r_rd_vld) begin
                            n_status = ST_MISS;
                            n_state  = S_DONE;
                        end else if (hit_used && data_eq) begin
                            wr_en    = (r_cmd == CMD_DELETE);
                            wr_data  = {1'b0, r_value};
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end else if (last_probe) begin
                            n_status = ST_MISS;
                            n_state  = S_DONE;
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_value      <= n_value;
        r_key        <= n_key;
        r_cnt        <= n_cnt;
        r_status     <= n_status;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HMLPT_ROWS; i++) begin
                r_hash_row[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_hash_row[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    // slot valid bits, a slot never written reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[rd_addr];
            if (wr_en) begin
                r_vld[slot] <= 1'b1;
            end
        end
    end

    // slot memory: used flag and value
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[slot] <= wr_data;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_status    = r_out_status;

    `HMLPT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && o_in_ready, !o_in_ready, "item accepted while busy")
    `HMLPT_ASSERT_NEXT(a_result_posted, i_clk, i_rst_n,
        r_state == S_DONE && (!r_out_vld || i_out_ready), o_out_valid && o_in_ready,
        "result not posted after done")
    `HMLPT_ASSERT_SAME(a_write_in_probe, i_clk, i_rst_n,
        wr_en, r_state == S_PROBE && n_state == S_DONE, "slot write outside last probe")
    `HMLPT_ASSERT_SAME(a_status_code, i_clk, i_rst_n,
        o_out_valid, o_status == ST_OK || o_status == ST_MISS || o_status == ST_FULL,
        "undefined status code")

endmodule
